>>> hdl/tbth_pkg.sv
// shared types, constants and codes for the two-byte tag hash table
`default_nettype none

package tbth_pkg;

   localparam int TABLE_SIZE = 1543;
   localparam int MAX_PROBES = 64;

   localparam int KEY_W    = 16;
   localparam int TYPE_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int HASH_W   = 32;
   localparam int SLOT_W   = $clog2(TABLE_SIZE);
   localparam int COUNT_W  = $clog2(TABLE_SIZE + 1);
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1080);

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [HASH_W-1:0] MIX_C0 = 32'h7ed55d16;
   localparam logic [HASH_W-1:0] MIX_C1 = 32'hc761c23c;
   localparam logic [HASH_W-1:0] MIX_C2 = 32'h165667b1;
   localparam logic [HASH_W-1:0] MIX_C3 = 32'hd3a2646c;
   localparam logic [HASH_W-1:0] MIX_C4 = 32'hfd7046c5;
   localparam logic [HASH_W-1:0] MIX_C5 = 32'hb55a4f09;

   // hash reduction: fold the upper half, then reciprocal multiply
   localparam longint unsigned FOLD_MOD = (64'd1 << (HASH_W / 2)) % TABLE_SIZE;
   localparam logic [SLOT_W-1:0] FOLD_MUL = SLOT_W'(FOLD_MOD);
   localparam int FOLD_W =
      $clog2(((64'd1 << (HASH_W / 2)) - 1) * (FOLD_MOD + 1) + 1);
   localparam int RECIP_SH = FOLD_W + SLOT_W;
   localparam longint unsigned RECIP_MUL =
      ((64'd1 << RECIP_SH) + TABLE_SIZE - 1) / TABLE_SIZE;
   localparam int RECIP_W = $clog2(RECIP_MUL + 1);
   localparam int PROD_W  = FOLD_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - RECIP_SH;

   // 2^32 mod table size, for probe sums that wrap
   localparam logic [SLOT_W-1:0] WRAP_REM = SLOT_W'((64'd1 << HASH_W) % TABLE_SIZE);

   localparam int PROBE_W = $clog2(MAX_PROBES + 2);
   localparam int OFF_MAX = (MAX_PROBES + 1) / 2 + (MAX_PROBES + 1) * (MAX_PROBES + 1) / 2;
   localparam int OFF_W   = $clog2(OFF_MAX + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND,
      STATUS_INSERTED,
      STATUS_FULL,
      STATUS_CLEARED
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_LOOK,
      ST_CHECK,
      ST_WIPE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TYPE_W-1:0] kind;
   } kt_entry_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } val_entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] addr;
      logic              rd_en;
      logic              kt_wr_en;
      logic              val_wr_en;
   } mem_cmd_type;

   typedef struct packed {
      logic [HASH_W-1:0] h;
      logic [SLOT_W-1:0] hm;
   } hash_res_type;

endpackage

`default_nettype wire

>>> hdl/tbth_if.sv
// request and response channel interfaces
`default_nettype none

interface tbth_req_if;
   import tbth_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [KEY_W-1:0]   tag_key;
   logic               write_enable;
   logic [TYPE_W-1:0]  type_in;
   logic [VALUE_W-1:0] value_in;

   modport source (output valid, output op, output tag_key, output write_enable,
                   output type_in, output value_in, input ready);
   modport sink (input valid, input op, input tag_key, input write_enable,
                 input type_in, input value_in, output ready);
endinterface

interface tbth_rsp_if;
   import tbth_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [TYPE_W-1:0]   type_out;
   logic [VALUE_W-1:0]  value_out;
   logic                has_value;
   logic [COUNT_W-1:0]  entry_total;

   modport source (output valid, output status, output slot, output type_out,
                   output value_out, output has_value, output entry_total, input ready);
   modport sink (input valid, input status, input slot, input type_out,
                 input value_out, input has_value, input entry_total, output ready);
endinterface

`default_nettype wire

>>> hdl/tbth_hash.sv
// tag mixing hash and reduction to a home slot, six-stage pipeline
`default_nettype none

module tbth_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tbth_pkg::KEY_W-1:0] key,
   output logic                       done,
   output tbth_pkg::hash_res_type     res
);
   import tbth_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [HASH_W-1:0] kx, a1, a2, b1, b2, c1, c2;
   logic [HASH_W-1:0] mixa_ff, mixb_ff, h_ff;
   logic [FOLD_W-1:0] fold_ff, fold_in, rem_full;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [QUOT_W-1:0] quot;
   logic [SLOT_W-1:0] hm_ff, hm_in;

   always_comb begin
      kx = HASH_W'(key);
      a1 = (kx + MIX_C0) + (kx << 12);
      a2 = (a1 ^ MIX_C1) ^ (a1 >> 19);
      b1 = (mixa_ff + MIX_C2) + (mixa_ff << 5);
      b2 = (b1 + MIX_C3) ^ (b1 << 9);
      c1 = (mixb_ff + MIX_C4) + (mixb_ff << 3);
      c2 = (c1 ^ MIX_C5) ^ (c1 >> 16);
      fold_in = FOLD_W'(h_ff[HASH_W-1:HASH_W/2]) * FOLD_W'(FOLD_MUL)
              + FOLD_W'(h_ff[HASH_W/2-1:0]);
      prod_in = PROD_W'(fold_ff) * PROD_W'(RECIP_MUL);
      // quotient is exact for every folded value
      quot = prod_ff[PROD_W-1:RECIP_SH];
      rem_full = fold_ff - FOLD_W'(quot) * FOLD_W'(TABLE_SIZE);
      hm_in = SLOT_W'(rem_full);
      vld_in = {vld_ff[STAGES-2:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mixa_ff <= a2;
      end
      if (vld_ff[0]) begin
         mixb_ff <= b2;
      end
      if (vld_ff[1]) begin
         h_ff <= c2;
      end
      if (vld_ff[2]) begin
         fold_ff <= fold_in;
      end
      if (vld_ff[3]) begin
         prod_ff <= prod_in;
      end
      if (vld_ff[4]) begin
         hm_ff <= hm_in;
      end
   end

   assign done   = vld_ff[STAGES-1];
   assign res.h  = h_ff;
   assign res.hm = hm_ff;

endmodule

`default_nettype wire

>>> hdl/tbth_store.sv
// slot memories: key and type word, value word with its valid bit
`default_nettype none

module tbth_store (
   input  logic                    clock,
   input  tbth_pkg::mem_cmd_type   cmd,
   input  tbth_pkg::kt_entry_type  kt_wr_data,
   input  tbth_pkg::val_entry_type val_wr_data,
   output tbth_pkg::kt_entry_type  kt_rd_data,
   output tbth_pkg::val_entry_type val_rd_data
);
   import tbth_pkg::*;

   kt_entry_type  kt_mem_ff  [TABLE_SIZE];
   val_entry_type val_mem_ff [TABLE_SIZE];
   kt_entry_type  kt_rd_ff;
   val_entry_type val_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.kt_wr_en) begin
         kt_mem_ff[cmd.addr] <= kt_wr_data;
      end
      if (cmd.rd_en) begin
         kt_rd_ff <= kt_mem_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.val_wr_en) begin
         val_mem_ff[cmd.addr] <= val_wr_data;
      end
      if (cmd.rd_en) begin
         val_rd_ff <= val_mem_ff[cmd.addr];
      end
   end

   assign kt_rd_data  = kt_rd_ff;
   assign val_rd_data = val_rd_ff;

endmodule

`default_nettype wire

>>> hdl/two_byte_tag_hash_table_unit.sv
// top level: request sequencer, probe address logic and response register
//
//   channel    dir   handshake               payload
//   req_port   in    valid / ready           op, tag_key, write_enable, type_in, value_in
//   rsp_port   out   valid / ready           status, slot, type_out, value_out,
//                                            has_value, entry_total
//   csr        in    csr_write_enable        csr_write_data (load limit)
//
// one request at a time; an access with a nonzero tag is accepted, passes through the
// hash pipeline, then a read and a compare of the slot memories for each probe
// a clear request sweeps the value memory, one slot a cycle, over all 1543 slots
// after reset all 1543 slots of the slot memories are swept before req_port.ready rises
// a response waits in its output register; the sequencer stalls only when a second
// response is ready before the first one is taken
`default_nettype none

module two_byte_tag_hash_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   tbth_req_if.sink                     req_port,
   tbth_rsp_if.source                   rsp_port,
   input  logic                         csr_write_enable,
   input  logic [tbth_pkg::COUNT_W-1:0] csr_write_data
);
   import tbth_pkg::*;

   localparam logic [SLOT_W:0]   TBL_X      = (SLOT_W + 1)'(TABLE_SIZE);
   localparam logic [SLOT_W-1:0] SWEEP_LAST = SLOT_W'(TABLE_SIZE - 1);
   localparam logic [PROBE_W-1:0] PROBE_END = PROBE_W'(MAX_PROBES + 1);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]  sweep_ff;
   logic [KEY_W-1:0]   tag_ff;
   logic               we_ff;
   logic [TYPE_W-1:0]  type_ff;
   logic [VALUE_W-1:0] value_ff;
   status_type         reply_status_ff;

   logic [SLOT_W-1:0]  addr_ff;
   logic [PROBE_W-1:0] probe_ff;
   logic [OFF_W-1:0]   off_ff, off_in, step;
   logic [SLOT_W-1:0]  offm_ff, offm_in;
   logic [SLOT_W:0]    offm_sum;

   logic [COUNT_W-1:0] count_ff, limit_ff;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [TYPE_W-1:0]   rsp_type_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_has_ff;
   logic [COUNT_W-1:0]  rsp_total_ff;

   logic               req_ready, accept, out_free;
   logic               hash_start, hash_done;
   hash_res_type       hash_res;
   mem_cmd_type        cmd;
   kt_entry_type       kt_wr, kt_rd;
   val_entry_type      val_wr, val_rd;

   logic               hit_key, hit_empty, last_probe, check_done, room;
   logic [HASH_W:0]    wrap_sum;
   logic [SLOT_W:0]    base_sum;
   logic [SLOT_W-1:0]  base, next_addr;

   logic               emit, count_inc;
   status_type         emit_status;
   logic [SLOT_W-1:0]  emit_slot;
   logic [TYPE_W-1:0]  emit_type;
   logic [VALUE_W-1:0] emit_value;
   logic               emit_has;
   logic [COUNT_W-1:0] emit_total;

   tbth_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_port.tag_key),
      .done  (hash_done),
      .res   (hash_res)
   );

   tbth_store u_store (
      .clock       (clock),
      .cmd         (cmd),
      .kt_wr_data  (kt_wr),
      .val_wr_data (val_wr),
      .kt_rd_data  (kt_rd),
      .val_rd_data (val_rd)
   );

   assign req_port.ready = req_ready;
   assign accept         = req_port.valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // slot compare
   always_comb begin
      hit_key    = (kt_rd.key == tag_ff);
      hit_empty  = (kt_rd.key == '0);
      last_probe = (probe_ff == PROBE_END);
      check_done = hit_key || hit_empty || last_probe;
      room       = ((COUNT_W + 1)'(count_ff) + (COUNT_W + 1)'(1)) < (COUNT_W + 1)'(limit_ff);
   end

   // next probe slot: (h + off) mod 2^32, reduced modulo the table size
   always_comb begin
      wrap_sum = {1'b0, hash_res.h} + (HASH_W + 1)'(off_ff);
      base_sum = {1'b0, hash_res.hm} + {1'b0, offm_ff};
      base     = (base_sum >= TBL_X) ? SLOT_W'(base_sum - TBL_X) : SLOT_W'(base_sum);
      if (!wrap_sum[HASH_W]) begin
         next_addr = base;
      end else if (base >= WRAP_REM) begin
         next_addr = base - WRAP_REM;
      end else begin
         next_addr = SLOT_W'({1'b0, base} + TBL_X - {1'b0, WRAP_REM});
      end
   end

   // offset step from probe i to i + 1
   always_comb begin
      step     = OFF_W'(probe_ff) + (probe_ff[0] ? OFF_W'(2) : OFF_W'(0));
      off_in   = off_ff + step;
      offm_sum = {1'b0, offm_ff} + (SLOT_W + 1)'(step);
      offm_in  = (offm_sum >= TBL_X) ? SLOT_W'(offm_sum - TBL_X) : SLOT_W'(offm_sum);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_port.op == OP_CLEAR) begin
                  state_in = ST_WIPE;
               end else if (req_port.tag_key == '0) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!check_done) begin
               state_in = ST_LOOK;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WIPE: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      hash_start     = 1'b0;
      emit           = 1'b0;
      count_inc      = 1'b0;
      emit_status    = STATUS_FULL;
      emit_slot      = '0;
      emit_type      = '0;
      emit_value     = '0;
      emit_has       = 1'b0;
      cmd.addr       = addr_ff;
      cmd.rd_en      = 1'b0;
      cmd.kt_wr_en   = 1'b0;
      cmd.val_wr_en  = 1'b0;
      kt_wr.key      = tag_ff;
      kt_wr.kind     = we_ff ? type_ff : kt_rd.kind;
      val_wr.valid   = 1'b1;
      val_wr.value   = value_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.addr      = sweep_ff;
            cmd.kt_wr_en  = 1'b1;
            cmd.val_wr_en = 1'b1;
            kt_wr         = '0;
            val_wr        = '0;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            hash_start = accept && (req_port.op == OP_ACCESS) && (req_port.tag_key != '0);
         end
         ST_HASH: begin
         end
         ST_LOOK: begin
            cmd.rd_en = 1'b1;
         end
         ST_CHECK: begin
            if (check_done && out_free) begin
               emit = 1'b1;
               if (hit_key || (hit_empty && room)) begin
                  emit_status   = hit_key ? STATUS_FOUND : STATUS_INSERTED;
                  count_inc     = !hit_key;
                  emit_slot     = addr_ff;
                  emit_type     = we_ff ? type_ff : kt_rd.kind;
                  emit_has      = we_ff || val_rd.valid;
                  emit_value    = we_ff ? value_ff : (val_rd.valid ? val_rd.value : '0);
                  cmd.kt_wr_en  = !hit_key || we_ff;
                  cmd.val_wr_en = we_ff;
               end
            end
         end
         ST_WIPE: begin
            cmd.addr      = sweep_ff;
            cmd.val_wr_en = 1'b1;
            val_wr        = '0;
         end
         ST_REPLY: begin
            emit        = out_free;
            emit_status = reply_status_ff;
         end
         default: begin
         end
      endcase
      emit_total = count_inc ? (count_ff + COUNT_W'(1)) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INIT || state_ff == ST_WIPE) begin
            sweep_ff <= (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + SLOT_W'(1);
         end
         if (count_inc) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff          <= req_port.tag_key;
         we_ff           <= req_port.write_enable;
         type_ff         <= req_port.type_in;
         value_ff        <= req_port.value_in;
         reply_status_ff <= (req_port.op == OP_CLEAR) ? STATUS_CLEARED : STATUS_FULL;
      end
      if (state_ff == ST_HASH && hash_done) begin
         addr_ff  <= hash_res.hm;
         off_ff   <= '0;
         offm_ff  <= '0;
         probe_ff <= PROBE_W'(1);
      end else if (state_ff == ST_LOOK) begin
         off_ff   <= off_in;
         offm_ff  <= offm_in;
         probe_ff <= probe_ff + PROBE_W'(1);
      end else if (state_ff == ST_CHECK && !check_done) begin
         addr_ff <= next_addr;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_slot_ff   <= emit_slot;
         rsp_type_ff   <= emit_type;
         rsp_value_ff  <= emit_value;
         rsp_has_ff    <= emit_has;
         rsp_total_ff  <= emit_total;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.slot        = rsp_slot_ff;
   assign rsp_port.type_out    = rsp_type_ff;
   assign rsp_port.value_out   = rsp_value_ff;
   assign rsp_port.has_value   = rsp_has_ff;
   assign rsp_port.entry_total = rsp_total_ff;

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_status == STATUS_INSERTED) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("entry count did not advance on insert");

   a_write_scope: assert property (@(posedge clock) disable iff (reset)
      (cmd.kt_wr_en || cmd.val_wr_en) |-> (state_ff == ST_INIT || state_ff == ST_WIPE || emit))
      else $error("slot memory written outside a sweep or a response");

   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> (addr_ff < SLOT_W'(TABLE_SIZE)))
      else $error("probe slot beyond the table");

   a_hash_timing: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("hash result arrived outside the hash wait");

endmodule

`default_nettype wire
